// ===== rtl/core/obbsat_pkg.sv =====
// Package for the 2D oriented box overlap unit: widths, item types and codes.
// Used by the channel interfaces, the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package obbsat_pkg;

	// Field widths of an item
	localparam int COORD_WIDTH    = 24;
	localparam int AXIS_WIDTH     = 16;
	localparam int AXIS_FRAC_BITS = 14;
	localparam int HALF_WIDTH     = 22;

	// Derived datapath widths
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int COS_W   = 2 * AXIS_WIDTH - AXIS_FRAC_BITS;
	localparam int MUL_A_0 = (DIFF_W > COS_W + 1) ? DIFF_W : COS_W + 1;
	localparam int MUL_A_W = (MUL_A_0 > AXIS_WIDTH) ? MUL_A_0 : AXIS_WIDTH;
	localparam int MUL_B_W = (AXIS_WIDTH > HALF_WIDTH + 1) ? AXIS_WIDTH : HALF_WIDTH + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int MAG_W   = ACC_W - AXIS_FRAC_BITS;
	localparam int CMP_W   = MAG_W + 1;

	// Sequencer: eight products on each of four axes
	localparam int STEP_W = 3;
	localparam int AXIS_IDX_W = 2;
	localparam int CNT_W = STEP_W + AXIS_IDX_W;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_TEST = 1'b1
	} func_t;

	typedef enum logic [STEP_W-1:0] {
		ST_DX = 3'd0,
		ST_DY = 3'd1,
		ST_UX = 3'd2,
		ST_UY = 3'd3,
		ST_VX = 3'd4,
		ST_VY = 3'd5,
		ST_RU = 3'd6,
		ST_RV = 3'd7
	} step_t;

	typedef enum logic [AXIS_IDX_W-1:0] {
		AX_REF_U = 2'd0,
		AX_REF_V = 2'd1,
		AX_PRB_U = 2'd2,
		AX_PRB_V = 2'd3
	} axis_sel_t;

	typedef struct packed {
		logic                          func;
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [AXIS_WIDTH-1:0]  axis_u_x;
		logic signed [AXIS_WIDTH-1:0]  axis_u_y;
		logic signed [AXIS_WIDTH-1:0]  axis_v_x;
		logic signed [AXIS_WIDTH-1:0]  axis_v_y;
		logic [HALF_WIDTH-1:0]         half_u;
		logic [HALF_WIDTH-1:0]         half_v;
	} req_item_t;

	typedef struct packed {
		logic hit;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/obbsat_req_if.sv =====
// Request channel of the box overlap unit: valid, ready and one box item.
// Depends on obbsat_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface obbsat_req_if;
	logic                  valid;
	logic                  ready;
	obbsat_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/obbsat_rsp_if.sv =====
// Response channel of the box overlap unit: valid, ready and the hit flag.
// Depends on obbsat_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface obbsat_rsp_if;
	logic                  valid;
	logic                  ready;
	obbsat_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/obb_overlap_separating_axis_unit.sv =====
// Top level of the 2D oriented box overlap unit (separating axis test).
// Depends on obbsat_pkg, obbsat_req_if and obbsat_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

// A load item (func 0) stores the reference box and returns nothing. A test
// item (func 1) runs the probe box against the reference box on four axes
// and returns one hit flag, and req.ready stays low until the hit item shows
// on rsp. A single shared multiplier forms eight products per axis (two for
// the center projection, four for the axis cosines, two for the projected
// radius) over four axes; a drain state then finishes the last compare, and
// the out state loads the output register once no older response waits.
// A waiting response is held until taken; the unit is ready again as soon as
// it is loaded.
module obb_overlap_separating_axis_unit (
	input  wire            clk,
	input  wire            arst_n,
	obbsat_req_if.sink     req,
	obbsat_rsp_if.source   rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	// Reference box
	logic signed [obbsat_pkg::COORD_WIDTH-1:0] ref_cx_q, ref_cy_q;
	logic signed [obbsat_pkg::AXIS_WIDTH-1:0]  ref_ux_q, ref_uy_q, ref_vx_q, ref_vy_q;
	logic [obbsat_pkg::HALF_WIDTH-1:0]         ref_hu_q, ref_hv_q;

	// Probe box and center difference
	logic signed [obbsat_pkg::AXIS_WIDTH-1:0]  prb_ux_q, prb_uy_q, prb_vx_q, prb_vy_q;
	logic [obbsat_pkg::HALF_WIDTH-1:0]         prb_hu_q, prb_hv_q;
	logic signed [obbsat_pkg::DIFF_W-1:0]      dx_q, dy_q;

	logic [obbsat_pkg::CNT_W-1:0] cnt_q;
	obbsat_pkg::step_t            step;
	obbsat_pkg::axis_sel_t        axis;

	// Multiplier stage
	logic signed [obbsat_pkg::MUL_A_W-1:0] op_a;
	logic signed [obbsat_pkg::MUL_B_W-1:0] op_b;
	logic signed [obbsat_pkg::PROD_W-1:0]  prod_s1;
	obbsat_pkg::step_t                     step_s1;
	obbsat_pkg::axis_sel_t                 axis_s1;
	logic                                  vld_s1;

	// Accumulate stage
	logic signed [obbsat_pkg::ACC_W-1:0] acc_q;
	logic signed [obbsat_pkg::ACC_W-1:0] sum;
	logic [obbsat_pkg::ACC_W-1:0]        mag;
	logic [obbsat_pkg::MAG_W-1:0]        mag_sh;
	logic [obbsat_pkg::MAG_W-1:0]        cp_q;
	logic [obbsat_pkg::COS_W-1:0]        cu_q, cv_q;
	logic [obbsat_pkg::HALF_WIDTH-1:0]   own_half;
	logic [obbsat_pkg::CMP_W-1:0]        bound;
	logic                                sep_now;
	logic                                sep_q;

	logic hit_q;
	logic out_vld_q;
	logic req_fire;
	logic out_free;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data.hit = hit_q;

	assign step = obbsat_pkg::step_t'(cnt_q[obbsat_pkg::STEP_W-1:0]);
	assign axis = obbsat_pkg::axis_sel_t'(cnt_q[obbsat_pkg::CNT_W-1:obbsat_pkg::STEP_W]);

	// Select multiplier operands for the current axis and step
	always_comb begin
		logic signed [obbsat_pkg::AXIS_WIDTH-1:0] ax, ay, bux, buy, bvx, bvy;
		logic [obbsat_pkg::HALF_WIDTH-1:0]        ohu, ohv;
		ax  = ref_ux_q;
		ay  = ref_uy_q;
		bux = prb_ux_q;
		buy = prb_uy_q;
		bvx = prb_vx_q;
		bvy = prb_vy_q;
		ohu = prb_hu_q;
		ohv = prb_hv_q;
		unique case (axis) inside
			obbsat_pkg::AX_REF_U: begin
				ax = ref_ux_q;
				ay = ref_uy_q;
			end
			obbsat_pkg::AX_REF_V: begin
				ax = ref_vx_q;
				ay = ref_vy_q;
			end
			obbsat_pkg::AX_PRB_U, obbsat_pkg::AX_PRB_V: begin
				ax  = (axis == obbsat_pkg::AX_PRB_U) ? prb_ux_q : prb_vx_q;
				ay  = (axis == obbsat_pkg::AX_PRB_U) ? prb_uy_q : prb_vy_q;
				bux = ref_ux_q;
				buy = ref_uy_q;
				bvx = ref_vx_q;
				bvy = ref_vy_q;
				ohu = ref_hu_q;
				ohv = ref_hv_q;
			end
			default: begin
				ax = ref_ux_q;
			end
		endcase
		op_a = obbsat_pkg::MUL_A_W'(dx_q);
		op_b = obbsat_pkg::MUL_B_W'(ax);
		unique case (step)
			obbsat_pkg::ST_DX: begin
				op_a = obbsat_pkg::MUL_A_W'(dx_q);
				op_b = obbsat_pkg::MUL_B_W'(ax);
			end
			obbsat_pkg::ST_DY: begin
				op_a = obbsat_pkg::MUL_A_W'(dy_q);
				op_b = obbsat_pkg::MUL_B_W'(ay);
			end
			obbsat_pkg::ST_UX: begin
				op_a = obbsat_pkg::MUL_A_W'(bux);
				op_b = obbsat_pkg::MUL_B_W'(ax);
			end
			obbsat_pkg::ST_UY: begin
				op_a = obbsat_pkg::MUL_A_W'(buy);
				op_b = obbsat_pkg::MUL_B_W'(ay);
			end
			obbsat_pkg::ST_VX: begin
				op_a = obbsat_pkg::MUL_A_W'(bvx);
				op_b = obbsat_pkg::MUL_B_W'(ax);
			end
			obbsat_pkg::ST_VY: begin
				op_a = obbsat_pkg::MUL_A_W'(bvy);
				op_b = obbsat_pkg::MUL_B_W'(ay);
			end
			obbsat_pkg::ST_RU: begin
				op_a = $signed(obbsat_pkg::MUL_A_W'(cu_q));
				op_b = $signed(obbsat_pkg::MUL_B_W'(ohu));
			end
			obbsat_pkg::ST_RV: begin
				op_a = $signed(obbsat_pkg::MUL_A_W'(cv_q));
				op_b = $signed(obbsat_pkg::MUL_B_W'(ohv));
			end
			default: begin
				op_a = obbsat_pkg::MUL_A_W'(dx_q);
			end
		endcase
	end

	// Pair sum, magnitude and the per-axis compare
	always_comb begin
		sum    = acc_q + obbsat_pkg::ACC_W'(prod_s1);
		mag    = sum[obbsat_pkg::ACC_W-1] ? $unsigned(-sum) : $unsigned(sum);
		mag_sh = mag[obbsat_pkg::ACC_W-1:obbsat_pkg::AXIS_FRAC_BITS];
		unique case (axis_s1)
			obbsat_pkg::AX_REF_U: own_half = ref_hu_q;
			obbsat_pkg::AX_REF_V: own_half = ref_hv_q;
			obbsat_pkg::AX_PRB_U: own_half = prb_hu_q;
			obbsat_pkg::AX_PRB_V: own_half = prb_hv_q;
			default:              own_half = ref_hu_q;
		endcase
		bound = obbsat_pkg::CMP_W'(own_half)
		      + obbsat_pkg::CMP_W'(sum[obbsat_pkg::ACC_W-1:obbsat_pkg::AXIS_FRAC_BITS]);
		sep_now = obbsat_pkg::CMP_W'(cp_q) > bound;
	end

	// Sequencer and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_RUN);
			// load a finished result, else drop a taken one
			if (state_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (req_fire && req.data.func == obbsat_pkg::FUNC_TEST) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Reference box store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cx_q <= '0;
			ref_cy_q <= '0;
			ref_ux_q <= '0;
			ref_uy_q <= '0;
			ref_vx_q <= '0;
			ref_vy_q <= '0;
			ref_hu_q <= '0;
			ref_hv_q <= '0;
		end else if (req_fire && req.data.func == obbsat_pkg::FUNC_LOAD) begin
			ref_cx_q <= req.data.center_x;
			ref_cy_q <= req.data.center_y;
			ref_ux_q <= req.data.axis_u_x;
			ref_uy_q <= req.data.axis_u_y;
			ref_vx_q <= req.data.axis_v_x;
			ref_vy_q <= req.data.axis_v_y;
			ref_hu_q <= req.data.half_u;
			ref_hv_q <= req.data.half_v;
		end
	end

	// Datapath: capture probe, multiply, accumulate, compare
	always_ff @(posedge clk) begin
		if (req_fire && req.data.func == obbsat_pkg::FUNC_TEST) begin
			prb_ux_q <= req.data.axis_u_x;
			prb_uy_q <= req.data.axis_u_y;
			prb_vx_q <= req.data.axis_v_x;
			prb_vy_q <= req.data.axis_v_y;
			prb_hu_q <= req.data.half_u;
			prb_hv_q <= req.data.half_v;
			dx_q     <= obbsat_pkg::DIFF_W'(ref_cx_q) - obbsat_pkg::DIFF_W'(req.data.center_x);
			dy_q     <= obbsat_pkg::DIFF_W'(ref_cy_q) - obbsat_pkg::DIFF_W'(req.data.center_y);
			sep_q    <= 1'b0;
		end
		prod_s1 <= op_a * op_b;
		step_s1 <= step;
		axis_s1 <= axis;
		if (vld_s1) begin
			case (step_s1)
				obbsat_pkg::ST_DY: cp_q <= mag_sh;
				obbsat_pkg::ST_UY: cu_q <= mag_sh[obbsat_pkg::COS_W-1:0];
				obbsat_pkg::ST_VY: cv_q <= mag_sh[obbsat_pkg::COS_W-1:0];
				obbsat_pkg::ST_RV: sep_q <= sep_q | sep_now;
				default:           acc_q <= obbsat_pkg::ACC_W'(prod_s1);
			endcase
		end
		if (state_q == S_OUT && out_free) begin
			hit_q <= ~sep_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/obbsat_checker.sv =====
// Port checker for the box overlap unit, bound to the top level.
// Depends on obbsat_pkg for the function codes.
`timescale 1ns / 1ps
`default_nettype none

module obbsat_checker (
	input wire clk,
	input wire arst_n,
	input wire req_valid,
	input wire req_ready,
	input wire req_func,
	input wire rsp_valid,
	input wire rsp_ready,
	input wire rsp_hit
);

	// Hold a stalled response item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
		else $error("response item changed while stalled");

	// Drop ready while a test runs
	a_busy_after_test: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == obbsat_pkg::FUNC_TEST |=> !req_ready)
		else $error("ready high right after a test item");

	// A load item causes no response
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == obbsat_pkg::FUNC_LOAD && !rsp_valid
		|=> !rsp_valid)
		else $error("response after a load item");

	// A test item cannot answer in the next cycle
	a_test_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == obbsat_pkg::FUNC_TEST && !rsp_valid
		|=> !rsp_valid)
		else $error("response too early after a test item");

	// A new response comes with the unit ready again
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("response raised while still busy");

endmodule

bind obb_overlap_separating_axis_unit obbsat_checker u_obbsat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.data.func),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_hit   (rsp.data.hit)
);

`default_nettype wire
